// ===== rtl/rqad_pkg.sv =====
// shared types and constants for the affinity run queue
package rqad_pkg;

  // field widths of the stream words
  localparam int unsigned OpW     = 1;
  localparam int unsigned CtxIdW  = 8;
  localparam int unsigned ThreadW = 4;
  localparam int unsigned DepthW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned GrantW  = 8;
  localparam int unsigned OccW    = 5;

  // input tdata layout, lowest bit first
  localparam int unsigned InCtxLo    = 0;
  localparam int unsigned InOwnThdLo = InCtxLo + CtxIdW;
  localparam int unsigned InOwnDepLo = InOwnThdLo + ThreadW;
  localparam int unsigned InReqThdLo = InOwnDepLo + DepthW;
  localparam int unsigned InReqDepLo = InReqThdLo + ThreadW;
  localparam int unsigned InDataW    = ((InReqDepLo + DepthW + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int unsigned OutGrantLo = 0;
  localparam int unsigned OutOccLo   = OutGrantLo + GrantW;
  localparam int unsigned OutDataW   = ((OutOccLo + OccW + 7) / 8) * 8;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_NONE       = 2'd3
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_FIN  = 3'b100
  } fsm_e;

endpackage

// ===== rtl/run_queue_affinity_dispatch.sv =====
// fifo run queue of ready contexts with thread affinity dispatch
//
//  channel  dir  handshake                      tuser        tdata
//  s_axis   in   s_axis_tvalid/s_axis_tready    operation    request word
//  m_axis   out  m_axis_tvalid/m_axis_tready    status       result word
//
// an enqueue is accepted with the memory write, then the result follows.
// a dispatch reads the entry memory one entry a cycle from the oldest; the
// match is taken out and later entries move down one place through the same
// read and write ports as the scan goes on.
// reset empties the queue at once; the entry memory itself is not cleared.
// a stalled result is held in the output register; the next word is accepted
// meanwhile and its result waits until the output register frees up.
module run_queue_affinity_dispatch #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned THREAD_BITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: context_id, owner_thread, owner_depth, requester_thread,
  // requester_depth
  input  logic [rqad_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: operation
  input  logic [rqad_pkg::OpW-1:0]       s_axis_tuser,
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: granted_id, occupancy
  output logic [rqad_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: status
  output logic [rqad_pkg::StatusW-1:0]   m_axis_tuser
);

  localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW  = rqad_pkg::DepthW;
  localparam int unsigned EW  = ID_BITS + THREAD_BITS + DW;
  localparam int unsigned TW  = (THREAD_BITS > rqad_pkg::ThreadW) ? THREAD_BITS
                                                                   : rqad_pkg::ThreadW;
  // entry layout in memory: id, owner, depth from the lowest bit
  localparam int unsigned EOwnLo = ID_BITS;
  localparam int unsigned EDepLo = ID_BITS + THREAD_BITS;

  // input field split
  logic [rqad_pkg::CtxIdW-1:0]  in_ctx;
  logic [rqad_pkg::ThreadW-1:0] in_own_thd;
  logic [DW-1:0]                in_own_dep;
  logic [rqad_pkg::ThreadW-1:0] in_req_thd;
  logic [DW-1:0]                in_req_dep;

  assign in_ctx     = s_axis_tdata[rqad_pkg::InCtxLo +: rqad_pkg::CtxIdW];
  assign in_own_thd = s_axis_tdata[rqad_pkg::InOwnThdLo +: rqad_pkg::ThreadW];
  assign in_own_dep = s_axis_tdata[rqad_pkg::InOwnDepLo +: DW];
  assign in_req_thd = s_axis_tdata[rqad_pkg::InReqThdLo +: rqad_pkg::ThreadW];
  assign in_req_dep = s_axis_tdata[rqad_pkg::InReqDepLo +: DW];

  // control state
  rqad_pkg::fsm_e fsm_q, fsm_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic           found_q, found_d;
  logic           out_valid_q, out_valid_d;

  // payload registers
  logic [rqad_pkg::ThreadW-1:0]  req_thd_q, req_thd_d;
  logic [DW-1:0]                 req_dep_q, req_dep_d;
  rqad_pkg::status_e             res_status_q, res_status_d;
  logic [ID_BITS-1:0]            res_id_q, res_id_d;
  rqad_pkg::status_e             out_status_q;
  logic [rqad_pkg::GrantW-1:0]   out_id_q;
  logic [rqad_pkg::OccW-1:0]     out_occ_q;

  // entry memory
  logic [EW-1:0] ent_mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic in_fire;
  logic out_load;
  logic full;
  logic scan_last;
  logic ent_match;

  assign s_axis_tready = (fsm_q == rqad_pkg::FSM_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (fsm_q == rqad_pkg::FSM_FIN) && (!out_valid_q || m_axis_tready);
  assign full          = (count_q >= CW'(QUEUE_DEPTH));
  assign scan_last     = ((CW'(idx_q) + CW'(1)) == count_q);

  // match of the entry read out this cycle against the latched request; owner 0 matches any
  assign ent_match =
      (rd_data_q[EOwnLo +: THREAD_BITS] == '0) ||
      ((TW'(rd_data_q[EOwnLo +: THREAD_BITS]) == TW'(req_thd_q)) &&
       (rd_data_q[EDepLo +: DW] == req_dep_q));

  // read address: oldest entry at accept, next entry while scanning
  assign rd_addr = (fsm_q == rqad_pkg::FSM_SCAN) ? (idx_q + AW'(1)) : '0;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= ent_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    fsm_d        = fsm_q;
    count_d      = count_q;
    idx_d        = idx_q;
    found_d      = found_q;
    req_thd_d    = req_thd_q;
    req_dep_d    = req_dep_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    wr_en        = 1'b0;
    wr_addr      = AW'(count_q);
    wr_data      = {in_own_dep, THREAD_BITS'(in_own_thd), ID_BITS'(in_ctx)};
    unique case (fsm_q)
      rqad_pkg::FSM_IDLE: begin
        if (in_fire) begin
          req_thd_d = in_req_thd;
          req_dep_d = in_req_dep;
          idx_d     = '0;
          found_d   = 1'b0;
          res_id_d  = '0;
          if (rqad_pkg::op_e'(s_axis_tuser) == rqad_pkg::OP_ENQUEUE) begin
            fsm_d = rqad_pkg::FSM_FIN;
            if (full) begin
              res_status_d = rqad_pkg::ST_DROPPED;
            end else begin
              wr_en        = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = rqad_pkg::ST_ENQUEUED;
            end
          end else if (count_q == '0) begin
            fsm_d        = rqad_pkg::FSM_FIN;
            res_status_d = rqad_pkg::ST_NONE;
          end else begin
            fsm_d = rqad_pkg::FSM_SCAN;
          end
        end
      end
      rqad_pkg::FSM_SCAN: begin
        // entries after the match move down one place
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q - AW'(1);
          wr_data = rd_data_q;
        end else if (ent_match) begin
          found_d  = 1'b1;
          res_id_d = rd_data_q[ID_BITS-1:0];
        end
        if (scan_last) begin
          fsm_d = rqad_pkg::FSM_FIN;
          if (found_q || ent_match) begin
            count_d      = count_q - CW'(1);
            res_status_d = rqad_pkg::ST_DISPATCHED;
          end else begin
            res_status_d = rqad_pkg::ST_NONE;
          end
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      rqad_pkg::FSM_FIN: begin
        if (out_load) begin
          fsm_d = rqad_pkg::FSM_IDLE;
        end
      end
      default: begin
        fsm_d = rqad_pkg::FSM_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= rqad_pkg::FSM_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_thd_q    <= req_thd_d;
    req_dep_q    <= req_dep_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= rqad_pkg::GrantW'(res_id_q);
      out_occ_q    <= rqad_pkg::OccW'(count_q);
    end
  end

  // result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = rqad_pkg::OutDataW'({out_occ_q, out_id_q});

endmodule
